// ===== hdl/ckh_pkg.sv =====
// package: sizes, rank table and shared types of the canonical k-mer histogram
`default_nettype none
package ckh_pkg;

    localparam int K        = 4;
    localparam int BINS     = 136;
    localparam int CODES    = 1 << (2 * K);
    localparam int HIST_W   = 3 * (K - 1);
    localparam int FILL_W   = 4;
    localparam int BIN_W    = 8;
    localparam int CNT_W    = 16;
    localparam int BASE_W   = 3;
    localparam int CODE_W   = 2 * K;
    localparam int ADDR_W   = $clog2(BINS);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [BIN_W-1:0] t_rank_tab [CODES];

    typedef struct packed {
        logic             res;
        logic             kind;
        logic [BIN_W-1:0] bin;
        logic             other;
        logic             in_range;
    } t_kmer_req;

    function automatic t_rank_tab f_build_ranks();
        t_rank_tab tab;
        int        rank [CODES];
        int        next;
        int        rc;
        int        c;
        int        v;
        next = 0;
        for (int i = 0; i < CODES; i++) begin
            c  = i;
            rc = 0;
            for (int j = 0; j < K; j++) begin
                rc = (rc << 2) | (3 - (c & 3));
                c  = c >> 2;
            end
            if (i <= rc) begin
                rank[i] = next;
                next    = next + 1;
            end else begin
                rank[i] = rank[rc];
            end
            v = (rank[i] >= BINS) ? BINS - 1 : rank[i];
            tab[i] = BIN_W'(v);
        end
        return tab;
    endfunction

    localparam t_rank_tab RANK_TAB = f_build_ranks();

endpackage
`default_nettype wire

// ===== hdl/canonical_kmer_histogram.sv =====
// top level: stream ports, histogram update stage and result register
// two register stages: the update stage (r_s1) and the result register (r_out_*)
// throughput: one item per cycle unless the output stalls, set by one histogram
//   read-modify-write per cycle (registered ram read, one-entry bypass of the last write)
// a result register lets a new item in while a finished result waits
// synchronous active-low reset clears the window, fill count and all bins at once
`default_nettype none
module canonical_kmer_histogram
    import ckh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // base[2:0], bin_select[10:3], zero pad
    input  wire logic [1:0]  i_s_axis_tuser,  // action[0], start_req[1]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,  // kmer_bin[7:0], bin_count[23:8]
    output logic      [1:0]  o_m_axis_tuser   // kind[0], had_other[1]
);

    t_kmer_req         req;
    logic              accept;
    logic              advance;
    logic              r_s1_vld;
    t_kmer_req         r_s1;
    logic [CNT_W-1:0]  old_cnt;
    logic [CNT_W-1:0]  inc_cnt;
    logic [CNT_W-1:0]  res_cnt;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;
    logic              r_out_vld;
    logic              r_out_kind;
    logic              r_out_other;
    logic [BIN_W-1:0]  r_out_bin;
    logic [CNT_W-1:0]  r_out_cnt;

    assign advance         = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_vld || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    ckh_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_s_axis_tuser[0]),
        .i_start  (i_s_axis_tuser[1]),
        .i_base   (i_s_axis_tdata[2:0]),
        .i_sel    (i_s_axis_tdata[10:3]),
        .o_req    (req)
    );

    ckh_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && req.res),
        .i_rd_addr (req.in_range ? req.bin[ADDR_W-1:0] : '0),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1.bin[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (old_cnt)
    );

    // saturating increment, clear on readout
    always_comb begin
        inc_cnt = (old_cnt == '1) ? old_cnt : old_cnt + CNT_W'(1);
        if (r_s1.kind == KIND_READ) begin
            res_cnt = r_s1.in_range ? old_cnt : '0;
            wr_data = '0;
        end else begin
            res_cnt = inc_cnt;
            wr_data = inc_cnt;
        end
        wr_en = r_s1_vld && advance && r_s1.in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_s1_vld <= accept && req.res;
            end
            if (advance) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_s1 <= req;
        end
        if (advance) begin
            r_out_kind  <= r_s1.kind;
            r_out_other <= r_s1.other;
            r_out_bin   <= r_s1.bin;
            r_out_cnt   <= res_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_cnt, r_out_bin};
    assign o_m_axis_tuser  = {r_out_other, r_out_kind};

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_COUNT)) |-> (r_out_cnt != '0))
        else $error("counted report with zero count");

    a_read_no_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_READ)) |-> !r_out_other)
        else $error("readout flagged with non-acgt base");

    a_other_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_COUNT) && r_out_other) |-> (r_out_bin == '0))
        else $error("non-acgt k-mer not in bin zero");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == KIND_COUNT)) |-> ({1'b0, r_out_bin} < (BIN_W + 1)'(BINS)))
        else $error("counted bin out of range");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !advance) |=> (r_s1_vld && $stable(r_s1)))
        else $error("update stage lost an item under stall");

endmodule
`default_nettype wire

// ===== hdl/ckh_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none
module ckh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 136
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ckh_window.sv =====
// base window, canonical code and bin lookup for each item
`default_nettype none
module ckh_window
    import ckh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_action,
    input  wire logic              i_start,
    input  wire logic [BASE_W-1:0] i_base,
    input  wire logic [BIN_W-1:0]  i_sel,
    output t_kmer_req              o_req
);

    logic [HIST_W-1:0] r_recent, n_recent;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] fill_eff;
    logic              full;
    logic [CODE_W-1:0] code;
    logic              other;
    logic [BASE_W-1:0] b;

    assign fill_eff = i_start ? '0 : r_fill;
    assign full     = (fill_eff >= FILL_W'(K - 1));

    always_comb begin
        code  = '0;
        other = 1'b0;
        for (int j = K - 2; j >= 0; j--) begin
            b     = r_recent[3*j +: BASE_W];
            other = other | b[2];
            code  = {code[CODE_W-3:0], b[1:0]};
        end
        b     = i_base;
        other = other | i_base[2];
        code  = {code[CODE_W-3:0], i_base[1:0]};
    end

    always_comb begin
        o_req          = '0;
        o_req.in_range = 1'b1;
        if (i_action == ACT_READ) begin
            o_req.res      = 1'b1;
            o_req.kind     = KIND_READ;
            o_req.bin      = i_sel;
            o_req.in_range = ({1'b0, i_sel} < (BIN_W + 1)'(BINS));
        end else begin
            o_req.res   = full;
            o_req.kind  = KIND_COUNT;
            o_req.other = other;
            o_req.bin   = other ? '0 : RANK_TAB[code];
        end
    end

    always_comb begin
        n_recent = r_recent;
        n_fill   = r_fill;
        if (i_accept && (i_action == ACT_PUSH)) begin
            n_recent = {r_recent[HIST_W-BASE_W-1:0], i_base};
            if (!full) begin
                n_fill = fill_eff + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_fill   <= '0;
        end else begin
            r_recent <= n_recent;
            r_fill   <= n_fill;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ckh_store.sv =====
// histogram counter store: ram, per-bin valid bits and last-write bypass
`default_nettype none
module ckh_store
    import ckh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [CNT_W-1:0]  i_wr_data,
    output logic      [CNT_W-1:0]  o_rd_data
);

    logic [BINS-1:0]   r_valid;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_lw_vld;
    logic [ADDR_W-1:0] r_lw_addr;
    logic [CNT_W-1:0]  r_lw_data;
    logic [CNT_W-1:0]  ram_q;

    ckh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_lw_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
            r_lw_vld           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_lw_addr <= i_wr_addr;
            r_lw_data <= i_wr_data;
        end
    end

    // newest write wins over the ram copy read in the same cycle
    always_comb begin
        if (r_lw_vld && (r_lw_addr == r_rd_addr)) begin
            o_rd_data = r_lw_data;
        end else if (r_valid[r_rd_addr]) begin
            o_rd_data = ram_q;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule
`default_nettype wire

// ===== tb/canonical_kmer_histogram_tb.sv =====
// testbench: canonical k-mer histogram driven through its streams, checked against a predictor
`timescale 1ns / 1ps
module canonical_kmer_histogram_tb;
    import ckh_pkg::*;

    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_C    = 3'd1;
    localparam logic [2:0] BASE_G    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_N    = 3'd4;
    localparam logic [2:0] BASE_LAST = 3'd7;
    localparam int         CNT_MAX   = (1 << CNT_W) - 1;
    localparam int         STALL_PCT = 14;
    localparam int         WATCHDOG  = 2000;
    localparam int         RAND_ITEMS = 1250;

    typedef struct packed {
        logic             action;
        logic             start;
        logic [2:0]       base;
        logic [BIN_W-1:0] sel;
    } t_item;

    typedef struct packed {
        logic             kind;
        logic [BIN_W-1:0] bin;
        logic [CNT_W-1:0] cnt;
        logic             other;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // base[2:0], bin_select[10:3], zero pad
    logic [1:0]  i_s_axis_tuser = '0;  // action[0], start_req[1]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;       // kmer_bin[7:0], bin_count[23:8]
    logic [1:0]  o_m_axis_tuser;       // kind[0], had_other[1]

    canonical_kmer_histogram u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_item            base_stream [$];
    t_report          kmer_reports [$];
    t_item            cur_item;
    logic [BIN_W-1:0] canonical_rank [CODES];
    logic [HIST_W-1:0] window_bases = '0;
    int               window_fill = 0;
    int               bin_hist [BINS];
    int               items_in = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    logic             calm;

    assign calm = (items_in >= 400) && (items_in < 800);

    function automatic int revcomp_code(int code);
        int r;
        r = 0;
        for (int i = 0; i < K; i++) begin
            r    = (r << 2) | (3 - (code & 3));
            code = code >> 2;
        end
        return r;
    endfunction

    // rank = number of canonical codes below the smaller of code and its reverse complement
    function automatic void build_rank_table();
        int low;
        int rank;
        for (int c = 0; c < CODES; c++) begin
            low  = (c < revcomp_code(c)) ? c : revcomp_code(c);
            rank = 0;
            for (int x = 0; x < low; x++)
                if (x <= revcomp_code(x))
                    rank++;
            if (rank >= BINS)
                rank = BINS - 1;
            canonical_rank[c] = BIN_W'(rank);
        end
    endfunction

    function automatic void count_kmer(t_item it);
        t_report          rep;
        logic [CODE_W-1:0] code;
        logic [2:0]       b;
        logic             other;
        int               bin;
        if (it.action == ACT_READ) begin
            rep.kind  = KIND_READ;
            rep.bin   = it.sel;
            rep.other = 1'b0;
            rep.cnt   = '0;
            if (it.sel < BINS) begin
                rep.cnt = CNT_W'(bin_hist[it.sel]);
                bin_hist[it.sel] = 0;
            end
            kmer_reports.insert(kmer_reports.size(), rep);
            return;
        end
        if (it.start)
            window_fill = 0;
        if (window_fill >= K - 1) begin
            code  = '0;
            other = 1'b0;
            for (int j = K - 2; j >= 0; j--) begin
                b = window_bases[3*j +: 3];
                if (b > BASE_T)
                    other = 1'b1;
                code = {code[CODE_W-3:0], b[1:0]};
            end
            if (it.base > BASE_T)
                other = 1'b1;
            code = {code[CODE_W-3:0], it.base[1:0]};
            bin  = other ? 0 : int'(canonical_rank[code]);
            if (bin_hist[bin] < CNT_MAX)
                bin_hist[bin]++;
            rep.kind  = KIND_COUNT;
            rep.bin   = BIN_W'(bin);
            rep.cnt   = CNT_W'(bin_hist[bin]);
            rep.other = other;
            kmer_reports.insert(kmer_reports.size(), rep);
        end else begin
            window_fill++;
        end
        window_bases = {window_bases[HIST_W-4:0], it.base};
    endfunction

    function automatic void push_base(logic start, logic [2:0] b);
        t_item it;
        it.action = ACT_PUSH;
        it.start  = start;
        it.base   = b;
        it.sel    = BIN_W'($urandom);
        base_stream.insert(base_stream.size(), it);
    endfunction

    function automatic void read_bin(logic [BIN_W-1:0] sel, logic start, logic [2:0] b);
        t_item it;
        it.action = ACT_READ;
        it.start  = start;
        it.base   = b;
        it.sel    = sel;
        base_stream.insert(base_stream.size(), it);
    endfunction

    function automatic logic [2:0] random_base();
        if ($urandom_range(0, 99) < 10)
            return 3'($urandom_range(BASE_N, BASE_LAST));
        return 3'($urandom_range(BASE_A, BASE_T));
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                count_kmer(cur_item);
                items_in++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (base_stream.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
                    cur_item = base_stream.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {5'b0, cur_item.sel, cur_item.base};
                    i_s_axis_tuser  <= {cur_item.start, cur_item.action};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind  = o_m_axis_tuser[0];
            got.other = o_m_axis_tuser[1];
            got.bin   = o_m_axis_tdata[7:0];
            got.cnt   = o_m_axis_tdata[23:8];
            if (kmer_reports.size() == 0) begin
                $display("%0t: unexpected item, expected none, got kind %0d bin %0d count %0d",
                         $time, got.kind, got.bin, got.cnt);
                mismatches++;
            end else begin
                want = kmer_reports.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("kmer_bin", want.bin, got.bin);
                check_field("bin_count", want.cnt, got.cnt);
                check_field("had_other", want.other, got.other);
            end
        end
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int added;
        int run_len;
        foreach (bin_hist[i])
            bin_hist[i] = 0;
        build_rank_table();

        // empty and out of range readouts
        read_bin(8'd0, 1'b0, BASE_A);
        read_bin(8'(BINS - 1), 1'b1, BASE_LAST);
        read_bin(8'(BINS), 1'b0, BASE_T);
        read_bin(8'hFF, 1'b1, BASE_N);
        // first full window, palindrome
        push_base(1'b1, BASE_A);
        push_base(1'b0, BASE_C);
        push_base(1'b0, BASE_G);
        push_base(1'b0, BASE_T);
        push_base(1'b0, BASE_T);
        read_bin(canonical_rank[8'h1B], 1'b0, BASE_G);
        // restart before the window fills, then all-T folds onto all-A
        push_base(1'b1, BASE_G);
        push_base(1'b0, BASE_G);
        push_base(1'b1, BASE_T);
        push_base(1'b0, BASE_T);
        push_base(1'b0, BASE_T);
        push_base(1'b0, BASE_T);
        // readout inside a window leaves the window alone; non-ACGT bases
        push_base(1'b1, BASE_C);
        push_base(1'b0, BASE_A);
        read_bin(8'd0, 1'b1, BASE_LAST);
        push_base(1'b0, BASE_N);
        push_base(1'b0, BASE_A);
        push_base(1'b0, BASE_LAST);
        push_base(1'b0, BASE_G);
        read_bin(8'd0, 1'b0, BASE_C);

        added = 0;
        while (added < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                run_len = $urandom_range(3, 20);
                push_base(1'b1, random_base());
                added++;
                for (int i = 0; i < run_len; i++) begin
                    if ($urandom_range(0, 99) < 10)
                        read_bin(8'($urandom_range(0, BINS - 1)), 1'($urandom), 3'($urandom));
                    else
                        push_base(1'b0, random_base());
                    added++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: read_bin(8'($urandom), 1'($urandom), 3'($urandom));
                    1: read_bin(8'($urandom_range(0, BINS - 1)), 1'($urandom), 3'($urandom));
                    default: push_base(1'($urandom), 3'($urandom));
                endcase
                added++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (base_stream.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (kmer_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ckh_pkg.sv
hdl/ckh_ram.sv
hdl/ckh_window.sv
hdl/ckh_store.sv
hdl/canonical_kmer_histogram.sv
tb/canonical_kmer_histogram_tb.sv
